/* rtl/core/lvs3d_pkg.sv */
`timescale 1ns / 1ps

package lvs3d_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned DRIFT_BITS = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DRIFT_BITS-1:0] drift_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  localparam int unsigned SWAP_XY = 0;
  localparam int unsigned SWAP_XZ = 1;

  localparam int unsigned SIGN_MAJOR   = 0;
  localparam int unsigned SIGN_MINOR_A = 1;
  localparam int unsigned SIGN_MINOR_B = 2;

  function automatic coord_t abs_diff(input coord_t a, input coord_t b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic coord_t step_coord(input coord_t pos, input logic down);
    step_coord = down ? (pos - coord_t'(1)) : (pos + coord_t'(1));
  endfunction

  function automatic drift_t widen(input coord_t v);
    widen = drift_t'({2'b00, v});
  endfunction

endpackage

/* rtl/core/line_voxel_stepper_3d_core.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid_i/in_stall_o  cmd, start_x/y/z, end_x/y/z
// out      output     out_valid_o/out_stall_i point_x/y/z, last_point
//
// One item per cycle: a start or step item is applied to the line state in the
// cycle it is accepted, and a step result appears in the output register the
// next cycle. The input stalls only while a result is held and the output stalls.
// Reset clears the line state, so steps give no result until a start.
// Start items produce no result.

module line_voxel_stepper_3d_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [lvs3d_pkg::COORD_BITS-1:0] start_x_i,
  input  logic [lvs3d_pkg::COORD_BITS-1:0] start_y_i,
  input  logic [lvs3d_pkg::COORD_BITS-1:0] start_z_i,
  input  logic [lvs3d_pkg::COORD_BITS-1:0] end_x_i,
  input  logic [lvs3d_pkg::COORD_BITS-1:0] end_y_i,
  input  logic [lvs3d_pkg::COORD_BITS-1:0] end_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lvs3d_pkg::COORD_BITS-1:0] point_x_o,
  output logic [lvs3d_pkg::COORD_BITS-1:0] point_y_o,
  output logic [lvs3d_pkg::COORD_BITS-1:0] point_z_o,
  output logic                          last_point_o
);

  lvs3d_pkg::coord_t major_pos_q, major_pos_d;
  lvs3d_pkg::coord_t major_end_q, major_end_d;
  lvs3d_pkg::coord_t minor_a_pos_q, minor_a_pos_d;
  lvs3d_pkg::coord_t minor_b_pos_q, minor_b_pos_d;
  lvs3d_pkg::coord_t major_delta_q, major_delta_d;
  lvs3d_pkg::coord_t minor_a_delta_q, minor_a_delta_d;
  lvs3d_pkg::coord_t minor_b_delta_q, minor_b_delta_d;
  lvs3d_pkg::drift_t drift_a_q, drift_a_d;
  lvs3d_pkg::drift_t drift_b_q, drift_b_d;
  logic [2:0]        step_signs_q, step_signs_d;
  logic [1:0]        axis_swaps_q, axis_swaps_d;
  logic              line_active_q, line_active_d;

  logic              out_valid_q, out_valid_d;
  lvs3d_pkg::coord_t point_x_q, point_x_d;
  lvs3d_pkg::coord_t point_y_q, point_y_d;
  lvs3d_pkg::coord_t point_z_q, point_z_d;
  logic              last_point_q, last_point_d;

  logic              in_accept;
  logic              out_accept;
  logic              is_start;
  logic              is_step;

  logic              swap_xy;
  logic              swap_xz;
  lvs3d_pkg::coord_t ax0, ay0, ax1, ay1;
  lvs3d_pkg::coord_t bx0, bz0, bx1, bz1;
  lvs3d_pkg::coord_t new_major_delta;

  lvs3d_pkg::coord_t cx, cy, cz;
  lvs3d_pkg::coord_t next_major;
  lvs3d_pkg::drift_t drift_a_sub, drift_b_sub;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign is_start   = in_accept && (lvs3d_pkg::cmd_e'(cmd_i) == lvs3d_pkg::CMD_START);
  assign is_step    = in_accept && (lvs3d_pkg::cmd_e'(cmd_i) == lvs3d_pkg::CMD_STEP)
                      && line_active_q;

  always_comb begin
    swap_xy = lvs3d_pkg::abs_diff(start_y_i, end_y_i) > lvs3d_pkg::abs_diff(start_x_i, end_x_i);
    ax0 = swap_xy ? start_y_i : start_x_i;
    ay0 = swap_xy ? start_x_i : start_y_i;
    ax1 = swap_xy ? end_y_i : end_x_i;
    ay1 = swap_xy ? end_x_i : end_y_i;
    swap_xz = lvs3d_pkg::abs_diff(start_z_i, end_z_i) > lvs3d_pkg::abs_diff(ax0, ax1);
    bx0 = swap_xz ? start_z_i : ax0;
    bz0 = swap_xz ? ax0 : start_z_i;
    bx1 = swap_xz ? end_z_i : ax1;
    bz1 = swap_xz ? ax1 : end_z_i;
    new_major_delta = lvs3d_pkg::abs_diff(bx0, bx1);
  end

  always_comb begin
    cx = major_pos_q;
    cy = minor_a_pos_q;
    cz = minor_b_pos_q;
    if (axis_swaps_q[lvs3d_pkg::SWAP_XZ]) begin
      cz = cx;
      cx = minor_b_pos_q;
    end
    if (axis_swaps_q[lvs3d_pkg::SWAP_XY]) begin
      cy = cx;
      cx = minor_a_pos_q;
    end
  end

  assign next_major  = lvs3d_pkg::step_coord(major_pos_q, step_signs_q[lvs3d_pkg::SIGN_MAJOR]);
  assign drift_a_sub = drift_a_q - lvs3d_pkg::widen(minor_a_delta_q);
  assign drift_b_sub = drift_b_q - lvs3d_pkg::widen(minor_b_delta_q);

  always_comb begin
    major_pos_d     = major_pos_q;
    major_end_d     = major_end_q;
    minor_a_pos_d   = minor_a_pos_q;
    minor_b_pos_d   = minor_b_pos_q;
    major_delta_d   = major_delta_q;
    minor_a_delta_d = minor_a_delta_q;
    minor_b_delta_d = minor_b_delta_q;
    drift_a_d       = drift_a_q;
    drift_b_d       = drift_b_q;
    step_signs_d    = step_signs_q;
    axis_swaps_d    = axis_swaps_q;
    line_active_d   = line_active_q;
    out_valid_d     = out_accept ? 1'b0 : out_valid_q;
    point_x_d       = point_x_q;
    point_y_d       = point_y_q;
    point_z_d       = point_z_q;
    last_point_d    = last_point_q;

    if (is_start) begin
      axis_swaps_d    = {swap_xz, swap_xy};
      major_delta_d   = new_major_delta;
      minor_a_delta_d = lvs3d_pkg::abs_diff(ay0, ay1);
      minor_b_delta_d = lvs3d_pkg::abs_diff(bz0, bz1);
      drift_a_d       = lvs3d_pkg::widen(new_major_delta >> 1);
      drift_b_d       = lvs3d_pkg::widen(new_major_delta >> 1);
      step_signs_d    = {bz0 > bz1, ay0 > ay1, bx0 > bx1};
      major_pos_d     = bx0;
      major_end_d     = bx1;
      minor_a_pos_d   = ay0;
      minor_b_pos_d   = bz0;
      line_active_d   = bx0 != bx1;
    end else if (is_step) begin
      out_valid_d  = 1'b1;
      point_x_d    = cx;
      point_y_d    = cy;
      point_z_d    = cz;
      last_point_d = next_major == major_end_q;
      drift_a_d    = drift_a_sub;
      drift_b_d    = drift_b_sub;
      if (drift_a_sub[lvs3d_pkg::DRIFT_BITS-1]) begin
        minor_a_pos_d = lvs3d_pkg::step_coord(minor_a_pos_q,
                                              step_signs_q[lvs3d_pkg::SIGN_MINOR_A]);
        drift_a_d     = drift_a_sub + lvs3d_pkg::widen(major_delta_q);
      end
      if (drift_b_sub[lvs3d_pkg::DRIFT_BITS-1]) begin
        minor_b_pos_d = lvs3d_pkg::step_coord(minor_b_pos_q,
                                              step_signs_q[lvs3d_pkg::SIGN_MINOR_B]);
        drift_b_d     = drift_b_sub + lvs3d_pkg::widen(major_delta_q);
      end
      major_pos_d = next_major;
      if (next_major == major_end_q) begin
        line_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_pos_q     <= '0;
      major_end_q     <= '0;
      minor_a_pos_q   <= '0;
      minor_b_pos_q   <= '0;
      major_delta_q   <= '0;
      minor_a_delta_q <= '0;
      minor_b_delta_q <= '0;
      drift_a_q       <= '0;
      drift_b_q       <= '0;
      step_signs_q    <= '0;
      axis_swaps_q    <= '0;
      line_active_q   <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      major_pos_q     <= major_pos_d;
      major_end_q     <= major_end_d;
      minor_a_pos_q   <= minor_a_pos_d;
      minor_b_pos_q   <= minor_b_pos_d;
      major_delta_q   <= major_delta_d;
      minor_a_delta_q <= minor_a_delta_d;
      minor_b_delta_q <= minor_b_delta_d;
      drift_a_q       <= drift_a_d;
      drift_b_q       <= drift_b_d;
      step_signs_q    <= step_signs_d;
      axis_swaps_q    <= axis_swaps_d;
      line_active_q   <= line_active_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    point_x_q    <= point_x_d;
    point_y_q    <= point_y_d;
    point_z_q    <= point_z_d;
    last_point_q <= last_point_d;
  end

  assign out_valid_o  = out_valid_q;
  assign point_x_o    = point_x_q;
  assign point_y_o    = point_y_q;
  assign point_z_o    = point_z_q;
  assign last_point_o = last_point_q;

`ifndef SYNTHESIS
  a_active_not_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> (major_pos_q != major_end_q))
    else $error("active line sits on its end point");

  a_drift_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !drift_a_q[lvs3d_pkg::DRIFT_BITS-1] && !drift_b_q[lvs3d_pkg::DRIFT_BITS-1])
    else $error("drift went negative");

  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(is_step))
    else $error("result without an accepted step");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_step && (next_major == major_end_q)) |=> !line_active_q)
    else $error("line still active after its last point");
`endif

endmodule

/* sim/line_voxel_stepper_3d_core_test.sv */
`timescale 1ns / 1ps

module line_voxel_stepper_3d_core_test;
  import lvs3d_pkg::*;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int RANDOM_ITEMS = 1400;

  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_SILENT,
    ROW_POINT
  } row_kind_e;

  typedef struct packed {
    cmd_e   cmd;
    coord_t sx;
    coord_t sy;
    coord_t sz;
    coord_t ex;
    coord_t ey;
    coord_t ez;
  } line_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } voxel_point_t;

  typedef struct packed {
    row_kind_e    kind;
    line_item_t   item;
    voxel_point_t point;
  } directed_row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_stall_o;
  logic   cmd_i;
  coord_t start_x_i;
  coord_t start_y_i;
  coord_t start_z_i;
  coord_t end_x_i;
  coord_t end_y_i;
  coord_t end_z_i;
  logic   out_valid_o;
  logic   out_stall_i;
  coord_t point_x_o;
  coord_t point_y_o;
  coord_t point_z_o;
  logic   last_point_o;

  line_voxel_stepper_3d_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .start_z_i   (start_z_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .end_z_i     (end_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .point_z_o   (point_z_o),
    .last_point_o(last_point_o)
  );

  directed_row_t directed_rows [25] = '{
    '{ROW_SILENT, '{CMD_STEP, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, '0},
    '{ROW_SILENT, '{CMD_START, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, '0},
    '{ROW_SILENT, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, '0},
    '{ROW_SILENT, '{CMD_START, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFE, 12'hFFF, 12'hFFF}, '0},
    '{ROW_POINT, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{12'hFFF, 12'hFFF, 12'hFFF, 1'b1}},
    '{ROW_SILENT, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, '0},
    '{ROW_SILENT, '{CMD_START, 12'h000, 12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF}, '0},
    '{ROW_POINT, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{12'h000, 12'h000, 12'h000, 1'b0}},
    '{ROW_MODEL, '{CMD_STEP, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555}, '0},
    '{ROW_MODEL, '{CMD_STEP, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA}, '0},
    '{ROW_SILENT, '{CMD_START, 12'h000, 12'hFFF, 12'h000, 12'h001, 12'h000, 12'h000}, '0},
    '{ROW_POINT, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{12'h000, 12'hFFF, 12'h000, 1'b0}},
    '{ROW_MODEL, '{CMD_STEP, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000}, '0},
    '{ROW_MODEL, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, '0},
    '{ROW_SILENT, '{CMD_START, 12'hAAA, 12'h555, 12'hFFF, 12'hAA8, 12'h557, 12'hFF0}, '0},
    '{ROW_POINT, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{12'hAAA, 12'h555, 12'hFFF, 1'b0}},
    '{ROW_MODEL, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, '0},
    '{ROW_MODEL, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, '0},
    '{ROW_SILENT, '{CMD_START, 12'h003, 12'h000, 12'hFFF, 12'h000, 12'h003, 12'hFFC}, '0},
    '{ROW_MODEL, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, '0},
    '{ROW_MODEL, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, '0},
    '{ROW_MODEL, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000}, '0},
    '{ROW_SILENT, '{CMD_STEP, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF}, '0},
    '{ROW_SILENT, '{CMD_START, 12'h555, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'h556}, '0},
    '{ROW_POINT, '{CMD_STEP, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000},
      '{12'h555, 12'hAAA, 12'h555, 1'b1}}
  };

  voxel_point_t pending_points[$];
  int           mismatch_count = 0;
  int           burst_left = 0;

  coord_t     ln_major_pos;
  coord_t     ln_major_end;
  coord_t     ln_minor_a_pos;
  coord_t     ln_minor_b_pos;
  coord_t     ln_major_delta;
  coord_t     ln_minor_a_delta;
  coord_t     ln_minor_b_delta;
  int         ln_drift_a;
  int         ln_drift_b;
  logic [2:0] ln_down;
  logic [1:0] ln_swaps;
  logic       ln_active;

  function automatic coord_t span(input coord_t a, input coord_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic coord_t nudge(input coord_t pos, input logic down);
    return down ? (pos - coord_t'(1)) : (pos + coord_t'(1));
  endfunction

  function automatic coord_t rnd_coord();
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  function automatic coord_t reach(input coord_t from, input int len);
    int v;
    v = int'(from) + int'($urandom_range(0, 2 * len)) - len;
    if (v < 0) begin
      v = 0;
    end else if (v > COORD_MAX) begin
      v = COORD_MAX;
    end
    return coord_t'(v);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  task automatic trace_line(input line_item_t it, output bit has_point,
                            output voxel_point_t pt);
    coord_t x0, y0, z0, x1, y1, z1, t, next_major;
    has_point = 1'b0;
    pt = '0;
    if (it.cmd == CMD_START) begin
      x0 = it.sx; y0 = it.sy; z0 = it.sz;
      x1 = it.ex; y1 = it.ey; z1 = it.ez;
      ln_swaps = '0;
      if (span(y0, y1) > span(x0, x1)) begin
        t = x0; x0 = y0; y0 = t;
        t = x1; x1 = y1; y1 = t;
        ln_swaps[SWAP_XY] = 1'b1;
      end
      if (span(z0, z1) > span(x0, x1)) begin
        t = x0; x0 = z0; z0 = t;
        t = x1; x1 = z1; z1 = t;
        ln_swaps[SWAP_XZ] = 1'b1;
      end
      ln_major_delta   = span(x0, x1);
      ln_minor_a_delta = span(y0, y1);
      ln_minor_b_delta = span(z0, z1);
      ln_drift_a = int'(ln_major_delta >> 1);
      ln_drift_b = int'(ln_major_delta >> 1);
      ln_down[SIGN_MAJOR]   = x0 > x1;
      ln_down[SIGN_MINOR_A] = y0 > y1;
      ln_down[SIGN_MINOR_B] = z0 > z1;
      ln_major_pos   = x0;
      ln_major_end   = x1;
      ln_minor_a_pos = y0;
      ln_minor_b_pos = z0;
      ln_active      = x0 != x1;
    end else if (ln_active) begin
      pt.x = ln_major_pos;
      pt.y = ln_minor_a_pos;
      pt.z = ln_minor_b_pos;
      if (ln_swaps[SWAP_XZ]) begin
        t = pt.x; pt.x = pt.z; pt.z = t;
      end
      if (ln_swaps[SWAP_XY]) begin
        t = pt.x; pt.x = pt.y; pt.y = t;
      end
      next_major = nudge(ln_major_pos, ln_down[SIGN_MAJOR]);
      pt.last = next_major == ln_major_end;
      has_point = 1'b1;
      ln_drift_a -= int'(ln_minor_a_delta);
      ln_drift_b -= int'(ln_minor_b_delta);
      if (ln_drift_a < 0) begin
        ln_minor_a_pos = nudge(ln_minor_a_pos, ln_down[SIGN_MINOR_A]);
        ln_drift_a += int'(ln_major_delta);
      end
      if (ln_drift_b < 0) begin
        ln_minor_b_pos = nudge(ln_minor_b_pos, ln_down[SIGN_MINOR_B]);
        ln_drift_b += int'(ln_major_delta);
      end
      ln_major_pos = next_major;
      if (ln_major_pos == ln_major_end) begin
        ln_active = 1'b0;
      end
    end
  endtask

  // Call at a falling edge; returns at a falling edge after the item is taken.
  task automatic send_item(input line_item_t it, input row_kind_e kind,
                           input voxel_point_t typed);
    bit           has_point;
    voxel_point_t pt;
    int           gap;
    int           r;
    cmd_i      <= it.cmd;
    start_x_i  <= it.sx;
    start_y_i  <= it.sy;
    start_z_i  <= it.sz;
    end_x_i    <= it.ex;
    end_y_i    <= it.ey;
    end_z_i    <= it.ez;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    trace_line(it, has_point, pt);
    if (kind == ROW_POINT) begin
      pending_points = {pending_points, typed};
    end else if (kind == ROW_MODEL && has_point) begin
      pending_points = {pending_points, pt};
    end
    @(negedge clk_i);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        burst_left = $urandom_range(20, 80);
      end else if (r >= 55 && r < 90) begin
        gap = $urandom_range(1, 3);
      end else if (r >= 90) begin
        gap = $urandom_range(6, 30);
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("FAIL line_voxel_stepper_3d_core");
    $finish;
  end

  initial begin
    int   cycle_count;
    int   hold_left;
    int   run_left;
    int   r;
    logic run_stall;
    out_stall_i = 1'b0;
    cycle_count = 0;
    hold_left = 0;
    run_left = 0;
    run_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      cycle_count++;
      // hold off long enough for the block to fill and stall its input
      if (hold_left == 0 && cycle_count % 2500 == 400) begin
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            run_stall = 1'b0;
            run_left = $urandom_range(1, 8);
          end else if (r < 65) begin
            run_stall = 1'b0;
            run_left = $urandom_range(40, 150);
          end else if (r < 93) begin
            run_stall = 1'b1;
            run_left = $urandom_range(1, 3);
          end else begin
            run_stall = 1'b1;
            run_left = $urandom_range(10, 40);
          end
        end
        run_left--;
        out_stall_i <= run_stall;
      end
    end
  end

  initial begin
    voxel_point_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_points.size() == 0) begin
          report_mismatch($sformatf("point %0d,%0d,%0d last %0d with none pending",
                                    point_x_o, point_y_o, point_z_o, last_point_o));
        end else begin
          want = pending_points.pop_front();
          if (point_x_o !== want.x) begin
            report_mismatch($sformatf("point_x got %0d want %0d", point_x_o, want.x));
          end
          if (point_y_o !== want.y) begin
            report_mismatch($sformatf("point_y got %0d want %0d", point_y_o, want.y));
          end
          if (point_z_o !== want.z) begin
            report_mismatch($sformatf("point_z got %0d want %0d", point_z_o, want.z));
          end
          if (last_point_o !== want.last) begin
            report_mismatch($sformatf("last_point got %0d want %0d", last_point_o,
                                      want.last));
          end
        end
      end
    end
  end

  initial begin
    line_item_t it;
    int         counted;
    int         r;
    int         len;
    int         n;
    int         steps;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    cmd_i      = CMD_START;
    start_x_i  = '0;
    start_y_i  = '0;
    start_z_i  = '0;
    end_x_i    = '0;
    end_y_i    = '0;
    end_z_i    = '0;
    ln_major_pos = '0;
    ln_major_end = '0;
    ln_minor_a_pos = '0;
    ln_minor_b_pos = '0;
    ln_major_delta = '0;
    ln_minor_a_delta = '0;
    ln_minor_b_delta = '0;
    ln_drift_a = 0;
    ln_drift_b = 0;
    ln_down = '0;
    ln_swaps = '0;
    ln_active = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item, directed_rows[i].kind, directed_rows[i].point);
    end

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      it.cmd = CMD_START;
      it.sx = rnd_coord(); it.sy = rnd_coord(); it.sz = rnd_coord();
      it.ex = rnd_coord(); it.ey = rnd_coord(); it.ez = rnd_coord();
      if (r < 8) begin
        it.cmd = CMD_STEP;
        if (ln_active) counted++;
        send_item(it, ROW_MODEL, '0);
      end else begin
        if (r >= 14) begin
          if ($urandom_range(0, 9) == 0) begin
            it.sx = ($urandom_range(0, 1) == 0) ? coord_t'(0) : coord_t'(COORD_MAX);
            it.sy = ($urandom_range(0, 1) == 0) ? coord_t'(0) : coord_t'(COORD_MAX);
            it.sz = ($urandom_range(0, 1) == 0) ? coord_t'(0) : coord_t'(COORD_MAX);
          end
          n = $urandom_range(0, 99);
          if (n < 80) begin
            len = $urandom_range(0, 20);
          end else if (n < 97) begin
            len = $urandom_range(21, 150);
          end else begin
            len = $urandom_range(151, COORD_MAX);
          end
          it.ex = reach(it.sx, len);
          it.ey = reach(it.sy, len);
          it.ez = reach(it.sz, len);
        end
        n = int'(span(it.sx, it.ex));
        if (int'(span(it.sy, it.ey)) > n) n = int'(span(it.sy, it.ey));
        if (int'(span(it.sz, it.ez)) > n) n = int'(span(it.sz, it.ez));
        counted++;
        send_item(it, ROW_MODEL, '0);
        if (r < 14) begin
          steps = $urandom_range(0, 6);
        end else if (n > 150) begin
          steps = $urandom_range(1, 150);
        end else if ($urandom_range(0, 9) == 0) begin
          steps = $urandom_range(0, n);
        end else begin
          steps = n + $urandom_range(0, 2);
        end
        repeat (steps) begin
          it.cmd = CMD_STEP;
          it.sx = rnd_coord(); it.sy = rnd_coord(); it.sz = rnd_coord();
          it.ex = rnd_coord(); it.ey = rnd_coord(); it.ez = rnd_coord();
          if (ln_active) counted++;
          send_item(it, ROW_MODEL, '0);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS line_voxel_stepper_3d_core");
    end else begin
      $display("FAIL line_voxel_stepper_3d_core");
    end
    $finish;
  end

endmodule
